// ----- hdl/double_ended_queue_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue package
// Request codes, cell control bundle and fixed constants.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned DATA_W = 32;

  // Value returned by every push and by a pop on an empty queue.
  localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;

  // Request codes.
  typedef enum logic [1:0] {
    FUNC_PUSH_BACK  = 2'd0,
    FUNC_POP_FRONT  = 2'd1,
    FUNC_PUSH_FRONT = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } deq_func_e;

  // Broadcast control to every cell; at most one field is set per cycle.
  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_back;
    logic pop_back;
  } deq_ctrl_t;

endpackage

// ----- hdl/deq_cell.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue cell
// One slot of the chain; shifts towards either neighbour, loads the item or empties itself.
// ----------------------------------------------------------------------------
module deq_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  deq_pkg::deq_ctrl_t           ctrl_i,
  input  logic [deq_pkg::DATA_W-1:0]   item_i,
  input  logic [deq_pkg::DATA_W-1:0]   prev_data_i,
  input  logic                         prev_valid_i,
  input  logic [deq_pkg::DATA_W-1:0]   next_data_i,
  input  logic                         next_valid_i,
  output logic [deq_pkg::DATA_W-1:0]   data_o,
  output logic                         valid_o,
  output logic                         last_o
);
  import deq_pkg::*;

  logic [DATA_W-1:0] data_q, data_d;
  logic              valid_q, valid_d;

  // Occupied cells are contiguous from the front; this one is the back item
  // when it is occupied and its successor is not.
  assign last_o  = valid_q & ~next_valid_i;
  assign data_o  = data_q;
  assign valid_o = valid_q;

  // Next contents of the cell.
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (ctrl_i.push_front) begin
      data_d  = prev_data_i;
      valid_d = prev_valid_i;
    end else if (ctrl_i.pop_front) begin
      data_d  = next_data_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.push_back) begin
      if (!valid_q && prev_valid_i) begin
        data_d  = item_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.pop_back) begin
      if (last_o) begin
        valid_d = 1'b0;
      end
    end
  end

  // Occupancy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stored item.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ----- hdl/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit items held in a chain of shifting cells.
// ----------------------------------------------------------------------------
//  Channel   Handshake                      Fields
//  request   in_valid_i / in_stall_o        func_i, item_i
//  result    out_valid_o / out_stall_i      popped_value_o, underflow_o,
//                                           overflow_o, occupancy_o
//
// One request is accepted per cycle while in_stall_o is low; its result appears in the cycle after.
// The front item always sits in the first cell, so pushes and pops at the
// front shift the whole chain by one place together; the back item
// is picked out by the cell whose successor is empty.
// Reset empties the queue at once; no clearing pass is needed.
// A request is taken whenever the result register is empty or being read.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          func_i,
  input  logic signed [deq_pkg::DATA_W-1:0]   item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [deq_pkg::DATA_W-1:0]   popped_value_o,
  output logic                                underflow_o,
  output logic                                overflow_o,
  output logic [CNT_W-1:0]                    occupancy_o
);
  import deq_pkg::*;

  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic              cell_valid [DEPTH];
  logic              cell_last  [DEPTH];

  deq_ctrl_t         ctrl;
  logic              accept;
  logic              full, empty;
  logic [DATA_W-1:0] back_data;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic              under_q, under_d;
  logic              over_q, over_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign full       = (cnt_q == CNT_W'(DEPTH));
  assign empty      = (cnt_q == '0);

  // Back item: exactly one occupied cell is marked last when not empty.
  always_comb begin
    back_data = '0;
    for (int unsigned k = 0; k < DEPTH; k++) begin
      back_data = back_data | (cell_data[k] & {DATA_W{cell_last[k]}});
    end
  end

  // Decode the request into cell control, flags and the new count.
  always_comb begin
    ctrl    = '0;
    cnt_d   = cnt_q;
    value_d = INT_MAX;
    under_d = 1'b0;
    over_d  = 1'b0;
    case (deq_func_e'(func_i))
      FUNC_PUSH_BACK: begin
        if (full) begin
          over_d = 1'b1;
        end else begin
          ctrl.push_back = accept;
          cnt_d          = cnt_q + CNT_W'(1);
        end
      end
      FUNC_PUSH_FRONT: begin
        if (full) begin
          over_d = 1'b1;
        end else begin
          ctrl.push_front = accept;
          cnt_d           = cnt_q + CNT_W'(1);
        end
      end
      FUNC_POP_FRONT: begin
        if (empty) begin
          under_d = 1'b1;
        end else begin
          ctrl.pop_front = accept;
          value_d        = cell_data[0];
          cnt_d          = cnt_q - CNT_W'(1);
        end
      end
      FUNC_POP_BACK: begin
        if (empty) begin
          under_d = 1'b1;
        end else begin
          ctrl.pop_back = accept;
          value_d       = back_data;
          cnt_d         = cnt_q - CNT_W'(1);
        end
      end
      default: begin
        under_d = 1'b0;
      end
    endcase
  end

  // Chain of cells; the first one sees the incoming item as its front
  // neighbour and the last one an empty neighbour behind it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] prev_data, next_data;
    logic              prev_valid, next_valid;

    if (i == 0) begin : g_first
      assign prev_data  = item_i;
      assign prev_valid = 1'b1;
    end else begin : g_mid_prev
      assign prev_data  = cell_data[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_final
      assign next_data  = '0;
      assign next_valid = 1'b0;
    end else begin : g_mid_next
      assign next_data  = cell_data[i+1];
      assign next_valid = cell_valid[i+1];
    end

    deq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .item_i       (item_i),
      .prev_data_i  (prev_data),
      .prev_valid_i (prev_valid),
      .next_data_i  (next_data),
      .next_valid_i (next_valid),
      .data_o       (cell_data[i]),
      .valid_o      (cell_valid[i]),
      .last_o       (cell_last[i])
    );
  end

  // Result register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state: fill count and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        cnt_q <= cnt_d;
      end
    end
  end

  // Result payload, loaded with each accepted request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= value_d;
      under_q <= under_d;
      over_q  <= over_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = value_q;
  assign underflow_o    = under_q;
  assign overflow_o     = over_q;
  assign occupancy_o    = cnt_q;

endmodule

// ----- hdl/deq_chk.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue port checker
// Watches the result port of the queue for consistent flags and counts.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module deq_chk #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  logic signed [deq_pkg::DATA_W-1:0]   popped_value_o,
  input  logic                                underflow_o,
  input  logic                                overflow_o,
  input  logic [CNT_W-1:0]                    occupancy_o
);
  import deq_pkg::*;

  logic                      at_empty;
  logic                      at_full;
  logic                      res_stalled;
  logic [DATA_W+CNT_W+1:0]   result_word;

  // Conditions that an underflow or an overflow result must meet.
  assign at_empty    = (occupancy_o == '0) && (popped_value_o == INT_MAX);
  assign at_full     = (occupancy_o == CNT_W'(DEPTH)) && (popped_value_o == INT_MAX);
  assign res_stalled = out_valid_o && out_stall_i;
  assign result_word = {popped_value_o, underflow_o, overflow_o, occupancy_o};

  // A request cannot both underflow and overflow.
  `DEQ_ASSERT_SAME(a_flags_exclusive, out_valid_o, !(underflow_o && overflow_o), "both flags")

  // An underflow only happens on an empty queue and returns the marker value.
  `DEQ_ASSERT_SAME(a_underflow_empty, out_valid_o && underflow_o, at_empty, "bad underflow")

  // An overflow only happens on a full queue and returns the marker value.
  `DEQ_ASSERT_SAME(a_overflow_full, out_valid_o && overflow_o, at_full, "bad overflow")

  // The count never exceeds the capacity.
  `DEQ_ASSERT_SAME(a_count_bound, out_valid_o, occupancy_o <= CNT_W'(DEPTH), "count too high")

  // A stalled result holds.
  `DEQ_ASSERT_NEXT(a_result_hold, res_stalled, out_valid_o && $stable(result_word), "moved")

endmodule

bind double_ended_queue deq_chk #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_deq_chk (.*);
